// File: design/rpb_pkg.sv
// Shared constants and helpers for the RGBA pixel blend core.
// No dependencies; imported by the interfaces and the core.
`timescale 1ns / 1ps
`default_nettype none

package rpb_pkg;

   localparam int CHAN_W   = 8;
   localparam int FACTOR_W = 9;
   localparam int MODE_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = FACTOR_W;
   localparam int LANES = 4;

   localparam logic [FACTOR_W-1:0] FACTOR_ONE = 9'd256;

   localparam logic [MODE_W-1:0] MODE_MIX    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUB    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MUL    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PREMUL = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR = 2'd1;

   // Bias so the premul numerator is never negative: 127 rounding + 255 * 512.
   localparam logic signed [18:0] PREMUL_BIAS = 19'sd130687;
   localparam logic signed [10:0] PREMUL_UNBIAS = 11'sd512;

   typedef logic [CHAN_W-1:0] chan_type;

   // floor(y / 255) for y below 196095, shift estimate plus small correction
   function automatic logic [9:0] div255(input logic [17:0] y);
      logic [9:0]  q0;
      logic [10:0] r;
      logic [9:0]  q;
      q0 = y[17:8];
      r  = {3'b000, y[7:0]} + {1'b0, q0};
      if (r >= 11'd765) begin
         q = q0 + 10'd3;
      end else if (r >= 11'd510) begin
         q = q0 + 10'd2;
      end else if (r >= 11'd255) begin
         q = q0 + 10'd1;
      end else begin
         q = q0;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// File: design/rpb_if.sv
// Request and response channel interfaces of the RGBA pixel blend core.
// Depends on rpb_pkg for the channel type.
`timescale 1ns / 1ps
`default_nettype none

interface rpb_req_if
   import rpb_pkg::*;
   ;
   logic     valid;
   logic     ready;
   chan_type base_red;
   chan_type base_green;
   chan_type base_blue;
   chan_type base_alpha;
   chan_type over_red;
   chan_type over_green;
   chan_type over_blue;
   chan_type over_alpha;

   modport source (
      output valid, base_red, base_green, base_blue, base_alpha,
             over_red, over_green, over_blue, over_alpha,
      input  ready
   );
   modport sink (
      input  valid, base_red, base_green, base_blue, base_alpha,
             over_red, over_green, over_blue, over_alpha,
      output ready
   );
endinterface

interface rpb_rsp_if
   import rpb_pkg::*;
   ;
   logic     valid;
   logic     ready;
   chan_type out_red;
   chan_type out_green;
   chan_type out_blue;
   chan_type out_alpha;

   modport source (
      output valid, out_red, out_green, out_blue, out_alpha,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, out_alpha,
      output ready
   );
endinterface

`default_nettype wire

// File: design/rgba_pixel_blend_core.sv
// RGBA pixel blend core: four-lane, four-stage blend pipeline with CSRs.
// Depends on rpb_pkg and the channel interfaces in rpb_if.sv.
//
//   channel    | direction | handshake     | payload
//   req_chan   | in        | valid/ready   | base and overlay RGBA, 8 bits each
//   rsp_chan   | out       | valid/ready   | blended RGBA, 8 bits each
//   csr        | in        | csr_wr_en     | csr_index (2b), csr_wdata (9b)
//
// One request per cycle sustained while rsp_chan is ready; each request passes
// through registered stages: products, scale/norm, second products, output.
// Each stage holds while the stage after it is full and stalled; a bubble is
// filled. Synchronous active-high reset clears valid bits and mode, sets factor to 256.
`timescale 1ns / 1ps
`default_nettype none

module rgba_pixel_blend_core
   import rpb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   rpb_req_if.sink                    req_chan,
   rpb_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MODE_W-1:0]   mode_ff;
   logic [FACTOR_W-1:0] factor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_MIX;
         factor_ff <= FACTOR_ONE;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_MODE) begin
            mode_ff <= csr_wdata[MODE_W-1:0];
         end else if (csr_index == CSR_FACTOR) begin
            factor_ff <= (csr_wdata > FACTOR_ONE) ? FACTOR_ONE : csr_wdata;
         end
      end
   end

   logic signed [9:0] fac_s;
   assign fac_s = $signed({1'b0, factor_ff});

   // stage valids and advance
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic adv1, adv2, adv3, adv_out;

   assign adv_out = !out_valid_ff || rsp_chan.ready;
   assign adv3    = !s3_valid_ff || adv_out;
   assign adv2    = !s2_valid_ff || adv3;
   assign adv1    = !s1_valid_ff || adv2;
   assign req_chan.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_chan.valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv_out) out_valid_ff <= s3_valid_ff;
      end
   end

   chan_type base_in [LANES];
   chan_type over_in [LANES];
   chan_type out_ff  [LANES];

   assign base_in[0] = req_chan.base_red;
   assign base_in[1] = req_chan.base_green;
   assign base_in[2] = req_chan.base_blue;
   assign base_in[3] = req_chan.base_alpha;
   assign over_in[0] = req_chan.over_red;
   assign over_in[1] = req_chan.over_green;
   assign over_in[2] = req_chan.over_blue;
   assign over_in[3] = req_chan.over_alpha;

   genvar ln;
   generate
      for (ln = 0; ln < LANES; ln++) begin : g_lane
         // stage 1: products
         logic signed [8:0]  diff_c;
         logic signed [18:0] diff_prod_c;
         logic [16:0]        over_prod_c;
         chan_type           s1_b_ff, s1_oa_ff;
         logic signed [17:0] s1_df_ff;
         logic [15:0]        s1_of_ff;
         logic [15:0]        s1_bo_ff;

         assign diff_c      = $signed({1'b0, over_in[ln]}) - $signed({1'b0, base_in[ln]});
         assign diff_prod_c = diff_c * fac_s;
         assign over_prod_c = over_in[ln] * factor_ff;

         always_ff @(posedge clock) begin
            if (adv1) begin
               s1_b_ff  <= base_in[ln];
               s1_oa_ff <= req_chan.over_alpha;
               s1_df_ff <= $signed(diff_prod_c[17:0]);
               s1_of_ff <= over_prod_c[15:0];
               s1_bo_ff <= base_in[ln] * over_in[ln];
            end
         end

         // stage 2: scale, mix/add/sub, premul difference, normalized product
         chan_type           scale_o_c;
         logic signed [17:0] df_sh_c;
         logic signed [9:0]  sdiff_c;
         logic [15:0]        bo_rnd_c;
         logic [9:0]         p_q_c;
         chan_type           s2_b_ff, s2_oa_ff, s2_p_ff;
         logic signed [9:0]  s2_a_ff, s2_m_ff, s2_s_ff, s2_d_ff;

         assign scale_o_c = s1_of_ff[15:8];
         assign df_sh_c   = s1_df_ff >>> 8;
         assign sdiff_c   = df_sh_c[9:0];
         assign bo_rnd_c  = s1_bo_ff + 16'd127;
         assign p_q_c     = div255({2'b00, bo_rnd_c});

         always_ff @(posedge clock) begin
            if (adv2) begin
               s2_b_ff  <= s1_b_ff;
               s2_oa_ff <= s1_oa_ff;
               s2_p_ff  <= p_q_c[7:0];
               s2_a_ff  <= $signed({2'b00, s1_b_ff}) + $signed({2'b00, scale_o_c});
               s2_m_ff  <= $signed({2'b00, s1_b_ff}) + sdiff_c;
               s2_s_ff  <= $signed({2'b00, s1_b_ff}) - $signed({2'b00, scale_o_c});
               s2_d_ff  <= sdiff_c - $signed({2'b00, scale_o_c});
            end
         end

         // stage 3: multiply lerp product and premul weight product
         logic signed [8:0]  pb_c;
         logic signed [18:0] mul_prod_c;
         logic signed [18:0] dq_prod_c;
         chan_type           s3_b_ff;
         logic signed [9:0]  s3_a_ff, s3_m_ff, s3_s_ff;
         logic signed [17:0] s3_mp_ff, s3_dq_ff;

         assign pb_c       = $signed({1'b0, s2_p_ff}) - $signed({1'b0, s2_b_ff});
         assign mul_prod_c = pb_c * fac_s;
         assign dq_prod_c  = s2_d_ff * $signed({1'b0, s2_oa_ff});

         always_ff @(posedge clock) begin
            if (adv3) begin
               s3_b_ff  <= s2_b_ff;
               s3_a_ff  <= s2_a_ff;
               s3_m_ff  <= s2_m_ff;
               s3_s_ff  <= s2_s_ff;
               s3_mp_ff <= $signed(mul_prod_c[17:0]);
               s3_dq_ff <= $signed(dq_prod_c[17:0]);
            end
         end

         // stage 4: finish, select, saturate
         logic signed [17:0] mp_sh_c;
         logic signed [10:0] mul_r_c;
         logic signed [18:0] dq_bias_c;
         logic [9:0]         pre_q_c;
         logic signed [10:0] pre_r_c;
         logic signed [10:0] res_c;
         chan_type           sat_c;

         assign mp_sh_c   = s3_mp_ff >>> 8;
         assign mul_r_c   = $signed({3'b000, s3_b_ff}) + mp_sh_c[10:0];
         assign dq_bias_c = $signed({s3_dq_ff[17], s3_dq_ff}) + PREMUL_BIAS;
         assign pre_q_c   = div255(dq_bias_c[17:0]);
         assign pre_r_c   = $signed({s3_a_ff[9], s3_a_ff}) + $signed({1'b0, pre_q_c})
                            - PREMUL_UNBIAS;

         always_comb begin
            unique case (mode_ff)
               MODE_MIX:    res_c = $signed({s3_m_ff[9], s3_m_ff});
               MODE_ADD:    res_c = $signed({s3_a_ff[9], s3_a_ff});
               MODE_SUB:    res_c = $signed({s3_s_ff[9], s3_s_ff});
               MODE_MUL:    res_c = mul_r_c;
               MODE_PREMUL: res_c = pre_r_c;
               default:     res_c = $signed({3'b000, s3_b_ff});
            endcase
            if (res_c < 11'sd0) begin
               sat_c = 8'd0;
            end else if (res_c > 11'sd255) begin
               sat_c = 8'd255;
            end else begin
               sat_c = res_c[7:0];
            end
         end

         always_ff @(posedge clock) begin
            if (adv_out) begin
               out_ff[ln] <= sat_c;
            end
         end
      end
   endgenerate

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_red   = out_ff[0];
   assign rsp_chan.out_green = out_ff[1];
   assign rsp_chan.out_blue  = out_ff[2];
   assign rsp_chan.out_alpha = out_ff[3];

endmodule

`default_nettype wire
